// ===== hw/rtl/rswb_pkg.sv =====
// ----------------------------------------------------------------------------
// rswb_pkg: shared definitions for the radial splat weight brush
// Field widths, register indexes and the structs passed between the
// divider stages and the channel lanes.
// ----------------------------------------------------------------------------
package rswb_pkg;

	localparam int COORD_W      = 12;
	localparam int RADIUS_W     = 12;
	localparam int OPAC_W       = 16;
	localparam int CHAN_W       = 4;
	localparam int WORD_W       = 64;
	localparam int BYTE_W       = 8;
	localparam int MAX_CHANNELS = 16;
	localparam int QUO_W        = 16;
	localparam int DIV_STAGES   = 4;
	localparam int DIV_STEPS    = QUO_W / DIV_STAGES;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam int DEF_CHANNELS   = 16;
	localparam int DEF_COORD_BITS = 12;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_COL     = 3'd0,
		REG_CENTER_ROW     = 3'd1,
		REG_RADIUS         = 3'd2,
		REG_OPACITY        = 3'd3,
		REG_TARGET_CHANNEL = 3'd4
	} cfg_reg_t;

	// One slice of the falloff divider: partial remainder, dividend bits
	// still to shift in, and quotient bits found so far.
	typedef struct packed {
		logic                ok;
		logic [RADIUS_W-1:0] rem;
		logic [QUO_W-1:0]    lo;
		logic [QUO_W-1:0]    quo;
	} div_t;

	// Per-lane control: apply the amount, and whether this lane gains it.
	typedef struct packed {
		logic              hit;
		logic              gain;
		logic [BYTE_W-1:0] amount;
	} lane_ctl_t;

endpackage

// ===== hw/rtl/rswb_div_stage.sv =====
// ----------------------------------------------------------------------------
// rswb_div_stage: one registered slice of the falloff divider
// Retires DIV_STEPS quotient bits by restoring division against the radius.
// ----------------------------------------------------------------------------
module rswb_div_stage (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rswb_pkg::RADIUS_W-1:0] radius,
	input  rswb_pkg::div_t                din,
	output rswb_pkg::div_t                dout
);

	rswb_pkg::div_t                 res_s1;
	rswb_pkg::div_t                 nxt;
	logic [rswb_pkg::RADIUS_W:0]    trial;

	always_comb begin
		nxt   = din;
		trial = '0;
		for (int k = 0; k < rswb_pkg::DIV_STEPS; k++) begin
			trial  = {nxt.rem, nxt.lo[rswb_pkg::QUO_W-1]};
			nxt.lo = {nxt.lo[rswb_pkg::QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, radius}) begin
				nxt.rem = rswb_pkg::RADIUS_W'(trial - {1'b0, radius});
				nxt.quo = {nxt.quo[rswb_pkg::QUO_W-2:0], 1'b1};
			end else begin
				nxt.rem = trial[rswb_pkg::RADIUS_W-1:0];
				nxt.quo = {nxt.quo[rswb_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1 <= nxt;
		end
	end

	assign dout = res_s1;

endmodule

// ===== hw/rtl/rswb_lane.sv =====
// ----------------------------------------------------------------------------
// rswb_lane: weight update for one mask channel
// On a hit, saturating add for the target channel, else saturating subtract.
// ----------------------------------------------------------------------------
module rswb_lane (
	input  logic [rswb_pkg::BYTE_W-1:0] w_in,
	input  rswb_pkg::lane_ctl_t         ctl,
	output logic [rswb_pkg::BYTE_W-1:0] w_out
);

	logic [rswb_pkg::BYTE_W:0] sum;

	assign sum = {1'b0, w_in} + {1'b0, ctl.amount};

	always_comb begin
		if (!ctl.hit) begin
			w_out = w_in;
		end else if (ctl.gain) begin
			w_out = sum[rswb_pkg::BYTE_W] ? '1 : sum[rswb_pkg::BYTE_W-1:0];
		end else begin
			w_out = (w_in >= ctl.amount) ? w_in - ctl.amount : '0;
		end
	end

endmodule

// ===== hw/rtl/radial_splat_weight_brush_unit.sv =====
// ----------------------------------------------------------------------------
// radial_splat_weight_brush_unit: round splat brush with quadratic falloff
// Paints one texel of a multi-channel splat mask per transfer.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Signals                  Carries
// s_axis   in   tvalid tready tdata      texel coordinates and 16 weights
// m_axis   out  tvalid tready tdata tuser updated weights, touched flag
// cfg      in   valid ready index data   brush centre, radius, opacity, target
//
// One texel per cycle while the skid register is empty; each result leaves
// through the output register. Depth is set by the falloff divider, four
// slices of four quotient bits each, behind the distance squaring stages.
// Reset clears the brush registers to defaults (radius 1) and empties the
// pipeline. When m_axis stalls with a result held, one more result parks in a
// skid register and the pipeline freezes until the skid drains.
// ----------------------------------------------------------------------------
module radial_splat_weight_brush_unit #(
	parameter int CHANNELS   = rswb_pkg::DEF_CHANNELS,
	parameter int COORD_BITS = rswb_pkg::DEF_COORD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// texel_col[11:0], texel_row[23:12], weights_low[87:24], weights_high[151:88]
	input  logic [2*rswb_pkg::COORD_W+2*rswb_pkg::WORD_W-1:0] s_axis_tdata,

	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// new_weights_low[63:0], new_weights_high[127:64]
	output logic [2*rswb_pkg::WORD_W-1:0]   m_axis_tdata,
	// touched[0]
	output logic [0:0]                      m_axis_tuser,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rswb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rswb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CB      = COORD_BITS;
	localparam int SQ_W    = 2 * CB;
	localparam int D2_W    = SQ_W + 1;
	localparam int R2_W    = 2 * rswb_pkg::RADIUS_W;
	localparam int CMP_W   = (D2_W > R2_W) ? D2_W : R2_W;
	localparam int WTS_W   = 2 * rswb_pkg::WORD_W;
	localparam int LAST    = 4 + rswb_pkg::DIV_STAGES;
	localparam int BW      = rswb_pkg::BYTE_W;
	localparam int CW      = rswb_pkg::COORD_W;

	// ---------------------------------------------------------------------
	// Brush registers: write only while the pipeline is idle; not enforced here.
	// ---------------------------------------------------------------------
	logic [CW-1:0]                    center_col_q;
	logic [CW-1:0]                    center_row_q;
	logic [rswb_pkg::RADIUS_W-1:0]    radius_q;
	logic [rswb_pkg::OPAC_W-1:0]      opacity_q;
	logic [rswb_pkg::CHAN_W-1:0]      target_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
			radius_q     <= rswb_pkg::RADIUS_RESET;
			opacity_q    <= '0;
			target_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (rswb_pkg::cfg_reg_t'(cfg_index))
				rswb_pkg::REG_CENTER_COL:     center_col_q <= cfg_data[CW-1:0];
				rswb_pkg::REG_CENTER_ROW:     center_row_q <= cfg_data[CW-1:0];
				rswb_pkg::REG_RADIUS:         radius_q <= cfg_data[rswb_pkg::RADIUS_W-1:0];
				rswb_pkg::REG_OPACITY:        opacity_q <= cfg_data[rswb_pkg::OPAC_W-1:0];
				rswb_pkg::REG_TARGET_CHANNEL: target_q <= cfg_data[rswb_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Flow control. The whole pipeline advances together unless the skid
	// register holds a result; ready therefore comes from a flop.
	// ---------------------------------------------------------------------
	logic adv;
	logic skid_valid_q;
	logic vld_s [1:LAST];
	logic [WTS_W-1:0] wts_s [1:LAST];

	assign adv           = !skid_valid_q;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Weights ride along untouched until the lanes.
	always_ff @(posedge clk) begin
		if (adv) begin
			wts_s[1] <= s_axis_tdata[2*CW +: WTS_W];
			for (int i = 2; i <= LAST; i++) begin
				wts_s[i] <= wts_s[i-1];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: absolute coordinate differences.
	// ---------------------------------------------------------------------
	logic [CB-1:0] tcol, trow, ccol, crow;
	logic [CB-1:0] dx_s1, dy_s1;

	assign tcol = CB'(s_axis_tdata[0 +: CW]);
	assign trow = CB'(s_axis_tdata[CW +: CW]);
	assign ccol = CB'(center_col_q);
	assign crow = CB'(center_row_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= (tcol >= ccol) ? tcol - ccol : ccol - tcol;
			dy_s1 <= (trow >= crow) ? trow - crow : crow - trow;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: squares of the differences and of the radius.
	// ---------------------------------------------------------------------
	logic [SQ_W-1:0] dx2_s2, dy2_s2;
	logic [R2_W-1:0] r2_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx2_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			dy2_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
			r2_s2  <= R2_W'(radius_q) * R2_W'(radius_q);
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: squared distance, inside test, divider seed.
	// The quotient d2*256/radius fits 16 bits only when d2 < radius*256;
	// beyond that the falloff exceeds any opacity, so drop the texel.
	// Under that bound d2 >> 8 is already below the radius.
	// ---------------------------------------------------------------------
	logic [D2_W-1:0]  d2;
	logic [CMP_W-1:0] d2x;
	logic             in_brush;
	rswb_pkg::div_t   div_chain [0:rswb_pkg::DIV_STAGES];

	assign d2       = D2_W'(dx2_s2) + D2_W'(dy2_s2);
	assign d2x      = CMP_W'(d2);
	assign in_brush = (radius_q != '0) && (d2x <= CMP_W'(r2_s2))
	                  && (d2x < (CMP_W'(radius_q) << BW));

	always_ff @(posedge clk) begin
		if (adv) begin
			div_chain[0].ok  <= in_brush;
			div_chain[0].rem <= in_brush ? d2x[BW +: rswb_pkg::RADIUS_W] : '0;
			div_chain[0].lo  <= {d2x[BW-1:0], {(rswb_pkg::QUO_W-BW){1'b0}}};
			div_chain[0].quo <= '0;
		end
	end

	// ---------------------------------------------------------------------
	// Stages 4..7: pipelined falloff divider.
	// ---------------------------------------------------------------------
	for (genvar g = 0; g < rswb_pkg::DIV_STAGES; g++) begin : g_div
		rswb_div_stage u_div (
			.clk    (clk),
			.en     (adv),
			.radius (radius_q),
			.din    (div_chain[g]),
			.dout   (div_chain[g+1])
		);
	end

	// ---------------------------------------------------------------------
	// Stage 8: brush amount, the integer part of opacity minus falloff.
	// ---------------------------------------------------------------------
	rswb_pkg::div_t              dq;
	logic [rswb_pkg::OPAC_W-1:0] diff;
	logic [BW-1:0]               amount_s8;
	logic                        hit_s8;

	assign dq   = div_chain[rswb_pkg::DIV_STAGES];
	assign diff = opacity_q - dq.quo;

	always_ff @(posedge clk) begin
		if (adv) begin
			amount_s8 <= diff[rswb_pkg::OPAC_W-1 -: BW];
			hit_s8    <= dq.ok && (opacity_q > dq.quo) && (diff[rswb_pkg::OPAC_W-1 -: BW] != '0);
		end
	end

	// ---------------------------------------------------------------------
	// Channel lanes, then merge into the output word. Bytes above the
	// configured channel count pass through.
	// ---------------------------------------------------------------------
	logic [WTS_W-1:0] merged;

	for (genvar c = 0; c < rswb_pkg::MAX_CHANNELS; c++) begin : g_lane
		if (c < CHANNELS) begin : g_act
			rswb_pkg::lane_ctl_t ctl;
			assign ctl.hit    = hit_s8;
			assign ctl.gain   = (target_q == rswb_pkg::CHAN_W'(c));
			assign ctl.amount = amount_s8;
			rswb_lane u_lane (
				.w_in  (wts_s[LAST][c*BW +: BW]),
				.ctl   (ctl),
				.w_out (merged[c*BW +: BW])
			);
		end else begin : g_pass
			assign merged[c*BW +: BW] = wts_s[LAST][c*BW +: BW];
		end
	end

	// ---------------------------------------------------------------------
	// Output register and skid. Advance the last stage into the output
	// register when it is free or being drained, else park it in the skid.
	// ---------------------------------------------------------------------
	logic             out_valid_q;
	logic [WTS_W-1:0] out_data_q, skid_data_q;
	logic             out_user_q, skid_user_q;
	logic             take;
	logic             load_out, load_skid;

	assign take      = out_valid_q && m_axis_tready;
	assign load_out  = adv && vld_s[LAST] && (!out_valid_q || take);
	assign load_skid = adv && vld_s[LAST] && out_valid_q && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (load_skid) begin
			skid_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (load_out) begin
			out_data_q <= merged;
			out_user_q <= hit_s8;
		end
		if (load_skid) begin
			skid_data_q <= merged;
			skid_user_q <= hit_s8;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_user_q;

endmodule
